[rtl/lz77_pkg.sv]
package lz77_pkg;

  typedef enum logic [2:0] {
    PH_FLAGS  = 3'd0,
    PH_ITEM   = 3'd1,
    PH_SYM1   = 3'd2,
    PH_NIBBLE = 3'd3,
    PH_LEN8   = 3'd4,
    PH_LEN16  = 3'd5,
    PH_LEN32  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_DRAIN = 2'd1,
    OP_END   = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DONE      = 3'd1,
    ST_BAD_OFS   = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_MISUSE    = 3'd5
  } status_e;

  localparam logic [31:0] LenBias = 32'd22;

  // decoder -> history unit: one byte to emit
  typedef struct packed {
    logic       wr;
    logic [7:0] data;
  } hist_wr_t;

endpackage

[rtl/lz77_hist.sv]
// History window: one synchronous RAM, one write and one read port.
module lz77_hist #(
  parameter int WINDOW_BYTES = 8192
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(WINDOW_BYTES)-1:0] waddr_i,
  input  logic [7:0]                      wdata_i,
  input  logic [$clog2(WINDOW_BYTES)-1:0] raddr_i,
  output logic [7:0]                      rdata_o
);
  logic [7:0] mem [WINDOW_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/lz77_plain_decompressor_top.sv]
// Channel   Dir  tdata fields (low bit up)                    tuser
// s_axis    in   in_byte[7:0]                                 op[1:0]
// m_axis    out  out_byte[7:0]                                {status,copy_pending,byte_valid}
//                                                              low bit up; tlast = last
// A literal or an empty result is accepted, then emitted. A match byte passes through history
// RAM read, emit and write back, turnaround; a burst of n bytes repeats these steps n times.
// Reset clears all control state; history content is undefined until written.
// Output stalls hold the sequencer; input is taken whenever the sequencer is idle.
module lz77_plain_decompressor_top #(
  parameter int WINDOW_BYTES = 8192,
  parameter int MAX_BURST    = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic [1:0] s_axis_tuser,   // op
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic [4:0] m_axis_tuser,   // byte_valid, copy_pending, status[2:0]
  output logic       m_axis_tlast
);
  import lz77_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int FW = AW + 1;
  localparam int BW = $clog2(MAX_BURST + 1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EMIT, S_OUT, S_FIN} seq_e;

  seq_e            st_q;
  logic [AW-1:0]   wp_q;
  logic [FW-1:0]   fill_q;
  logic [31:0]     flag_q;
  logic            nis_q;
  phase_e          ph_q;
  logic [31:0]     gat_q;
  logic [2:0]      gcnt_q;
  logic [FW-1:0]   ofs_q;
  logic            nh_q;
  logic [3:0]      nv_q;
  logic [32:0]     rem_q;
  logic [2:0]      sticky_q;
  logic [BW-1:0]   burst_q;
  logic [2:0]      rep_q;
  logic            lit_q;
  logic [7:0]      lit_byte_q;

  logic            ov_q, ol_q, obv_q;
  logic [7:0]      ob_q;
  logic [2:0]      ost_q;
  logic            ocp_q;

  hist_wr_t        hw;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;

  lz77_hist #(.WINDOW_BYTES(WINDOW_BYTES)) u_hist (
    .clk_i, .we_i(hw.wr), .waddr_i(wp_q), .wdata_i(hw.data),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // read index: wp - offset modulo window (offset in 1..window)
  logic [FW-1:0] ridx;
  assign ridx  = {1'b0, wp_q} + FW'(WINDOW_BYTES) - ofs_q;
  assign raddr = (ridx >= FW'(WINDOW_BYTES)) ? AW'(ridx - FW'(WINDOW_BYTES)) : ridx[AW-1:0];

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = ob_q;
  assign m_axis_tuser  = {ost_q, ocp_q, obv_q};
  assign m_axis_tlast  = ol_q;

  logic emitting;
  always_comb begin
    hw.wr   = 1'b0;
    hw.data = lit_q ? lit_byte_q : rdata;
    emitting = (st_q == S_EMIT) && !ov_q;
    hw.wr   = emitting;
  end

  logic [15:0] sym;
  assign sym = {s_axis_tdata, gat_q[7:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] g;
    logic [2:0]  gc;
    logic [31:0] fl;
    logic        do_match;
    logic [32:0] mlen;
    logic        newflag;
    if (!rst_ni) begin
      st_q <= S_IDLE; wp_q <= '0; fill_q <= '0; flag_q <= '0; nis_q <= 1'b1;
      ph_q <= PH_FLAGS; gat_q <= '0; gcnt_q <= '0; ofs_q <= '0; nh_q <= 1'b0;
      nv_q <= '0; rem_q <= '0; sticky_q <= '0; burst_q <= '0; rep_q <= '0;
      lit_q <= 1'b0; lit_byte_q <= '0; ov_q <= 1'b0; ol_q <= 1'b0; obv_q <= 1'b0;
      ob_q <= '0; ost_q <= '0; ocp_q <= 1'b0;
    end else begin
      do_match = 1'b0; mlen = '0; newflag = 1'b0;
      g = gat_q; gc = gcnt_q;
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            burst_q <= '0;
            if (sticky_q != ST_OK) begin
              rep_q <= sticky_q; st_q <= S_FIN;
            end else if (s_axis_tuser == OP_BAD ||
                         ((s_axis_tuser == OP_DRAIN) == (rem_q == '0))) begin
              rep_q <= ST_MISUSE; st_q <= S_FIN;
            end else if (s_axis_tuser == OP_DRAIN) begin
              rep_q <= ST_OK; st_q <= S_RD;
            end else if (s_axis_tuser == OP_END) begin
              fl = ~flag_q;
              if (((ph_q == PH_ITEM) || (ph_q == PH_FLAGS && gcnt_q == '0)) && nis_q &&
                  (((fl + 32'd1) & fl) == '0)) begin
                sticky_q <= ST_DONE; rep_q <= ST_DONE;
              end else begin
                sticky_q <= ST_TRUNC; rep_q <= ST_TRUNC;
              end
              st_q <= S_FIN;
            end else begin
              rep_q <= ST_OK; st_q <= S_FIN;
              case (ph_q)
                PH_ITEM: begin
                  if (!nis_q) begin
                    lit_q <= 1'b1; lit_byte_q <= s_axis_tdata; st_q <= S_EMIT;
                  end else begin
                    gat_q <= {24'd0, s_axis_tdata}; ph_q <= PH_SYM1;
                  end
                end
                PH_SYM1: begin
                  ofs_q <= FW'(sym[15:3]) + FW'(1);
                  gat_q <= '0; gcnt_q <= '0;
                  if (sym[2:0] != 3'd7) begin
                    do_match = 1'b1; mlen = 33'(sym[2:0]) + 33'd3;
                  end else if (nh_q) begin
                    nh_q <= 1'b0;
                    if (nv_q != 4'hF) begin do_match = 1'b1; mlen = 33'(nv_q) + 33'd10; end
                    else ph_q <= PH_LEN8;
                  end else ph_q <= PH_NIBBLE;
                end
                PH_NIBBLE: begin
                  nh_q <= 1'b1; nv_q <= s_axis_tdata[7:4];
                  if (s_axis_tdata[3:0] != 4'hF) begin
                    do_match = 1'b1; mlen = 33'(s_axis_tdata[3:0]) + 33'd10;
                  end else ph_q <= PH_LEN8;
                end
                PH_LEN8: begin
                  if (s_axis_tdata != 8'hFF) begin
                    do_match = 1'b1; mlen = 33'(s_axis_tdata) + 33'd25;
                  end else begin
                    ph_q <= PH_LEN16; gat_q <= '0; gcnt_q <= '0;
                  end
                end
                default: begin
                  g = gat_q | (32'(s_axis_tdata) << {gcnt_q[1:0], 3'b000});
                  gc = gcnt_q + 3'd1;
                  gat_q <= g; gcnt_q <= gc;
                  if (ph_q == PH_LEN16 && gc >= 3'd2) begin
                    gat_q <= '0; gcnt_q <= '0;
                    if (g == '0) ph_q <= PH_LEN32;
                    else if (g < LenBias) begin sticky_q <= ST_BAD_LEN; rep_q <= ST_BAD_LEN; end
                    else begin do_match = 1'b1; mlen = 33'(g) + 33'd3; end
                  end else if (ph_q == PH_LEN32 && gc >= 3'd4) begin
                    gat_q <= '0; gcnt_q <= '0;
                    if (g < LenBias) begin sticky_q <= ST_BAD_LEN; rep_q <= ST_BAD_LEN; end
                    else begin do_match = 1'b1; mlen = 33'(g) + 33'd3; end
                  end else if (ph_q == PH_FLAGS && gc >= 3'd4) begin
                    gat_q <= '0; gcnt_q <= '0;
                    nis_q <= g[31]; flag_q <= {g[30:0], 1'b1}; ph_q <= PH_ITEM;
                  end
                end
              endcase
              if (do_match) begin
                ph_q <= PH_ITEM; gat_q <= '0; gcnt_q <= '0;
                // offset compares against fill using the new offset
                if ((ph_q == PH_SYM1 ? (FW'(sym[15:3]) + FW'(1)) : ofs_q) > fill_q) begin
                  sticky_q <= ST_BAD_OFS; rep_q <= ST_BAD_OFS;
                end else begin
                  rem_q <= mlen; st_q <= S_RD;
                end
              end
            end
          end
        end
        S_RD: begin
          // RAM address settles this cycle; data valid next
          lit_q <= 1'b0; st_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!ov_q) begin
            wp_q <= (wp_q == AW'(WINDOW_BYTES - 1)) ? '0 : wp_q + AW'(1);
            if (fill_q < FW'(WINDOW_BYTES)) fill_q <= fill_q + FW'(1);
            ob_q <= hw.data; obv_q <= 1'b1; ov_q <= 1'b1;
            if (lit_q) begin
              lit_q <= 1'b0;
              newflag = 1'b1;
              ol_q <= 1'b1; ocp_q <= 1'b0; ost_q <= ST_OK; st_q <= S_IDLE;
            end else begin
              rem_q <= rem_q - 33'd1;
              burst_q <= burst_q + BW'(1);
              ost_q <= rep_q;
              // pending flag reflects the count left once this burst is over
              ocp_q <= (rem_q > (33'(MAX_BURST) - 33'(burst_q)));
              if (rem_q == 33'd1) begin
                newflag = 1'b1;
                ol_q <= 1'b1; st_q <= S_IDLE;
              end else if (burst_q == BW'(MAX_BURST - 1)) begin
                ol_q <= 1'b1; st_q <= S_IDLE;
              end else begin
                ol_q <= 1'b0; st_q <= S_OUT;
              end
            end
          end
        end
        S_OUT: begin
          // turnaround state between two history bytes
          st_q <= S_RD;
        end
        default: begin
          if (!ov_q) begin
            ob_q <= '0; obv_q <= 1'b0; ol_q <= 1'b1; ov_q <= 1'b1;
            ost_q <= rep_q; ocp_q <= (rem_q != '0); st_q <= S_IDLE;
          end
        end
      endcase
      if (newflag) begin
        nis_q <= flag_q[31];
        flag_q <= flag_q << 1;
        if ((flag_q << 1) != '0) ph_q <= PH_ITEM;
        else begin ph_q <= PH_FLAGS; gat_q <= '0; gcnt_q <= '0; end
      end
    end
  end
endmodule

[tb/lz77_plain_decompressor_top_tb.sv]
`timescale 1ns / 100ps

module lz77_plain_decompressor_top_tb;
  import lz77_pkg::*;

  localparam int Window = 8192;
  localparam int Burst  = 64;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } comp_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       copy_pending;
    status_e    status;
  } plain_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // in_byte
  logic [1:0] s_axis_tuser = '0;   // op
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // out_byte
  logic [4:0] m_axis_tuser;        // byte_valid, copy_pending, status[2:0]
  logic       m_axis_tlast;

  lz77_plain_decompressor_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // decoder mirror state
  logic [7:0]  win_mem [Window];
  logic [12:0] wr_ptr;
  int unsigned win_fill;
  logic [31:0] flags;
  bit          sym_next;
  phase_e      phase;
  logic [31:0] gath;
  int unsigned gath_cnt;
  int unsigned ofs;
  bit          nib_held;
  logic [3:0]  nib_val;
  longint unsigned copy_left;
  status_e     sticky;

  plain_byte_t expected_bytes[$];
  plain_byte_t item_bytes[$];
  comp_item_t  pending_items[$];
  int mismatches = 0;
  bit hold_rx = 1'b0;
  bit hold_tx = 1'b0;

  function automatic void emit(logic [7:0] b);
    plain_byte_t r;
    if (item_bytes.size() < Burst) begin
      r = '0;
      r.out_byte = b;
      r.byte_valid = 1'b1;
      item_bytes = {item_bytes, r};
    end
    win_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 13'd1;
    if (win_fill < Window) win_fill++;
  endfunction

  function automatic void advance_flag();
    sym_next = flags[31];
    flags = flags << 1;
    if (flags != 0) begin
      phase = PH_ITEM;
    end else begin
      phase = PH_FLAGS;
      gath = '0;
      gath_cnt = 0;
    end
  endfunction

  function automatic void copy_burst();
    int n;
    n = 0;
    while (copy_left != 0 && n < Burst) begin
      emit(win_mem[13'(wr_ptr - 13'(ofs))]);
      copy_left--;
      n++;
    end
    if (copy_left == 0) advance_flag();
  endfunction

  function automatic void begin_match(longint unsigned len);
    phase = PH_ITEM;
    gath = '0;
    gath_cnt = 0;
    if (ofs > win_fill) begin
      sticky = ST_BAD_OFS;
    end else begin
      copy_left = len;
      copy_burst();
    end
  endfunction

  function automatic void nibble_len(logic [3:0] n);
    if (n < 4'hF) begin
      begin_match(n + 10);
    end else begin
      phase = PH_LEN8;
    end
  endfunction

  function automatic void take_gather(logic [7:0] b);
    gath |= 32'(b) << (8 * (gath_cnt & 3));
    gath_cnt = (gath_cnt + 1) & 7;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [15:0] v;
    case (phase)
      PH_ITEM: begin
        if (!sym_next) begin
          emit(b);
          advance_flag();
        end else begin
          gath = 32'(b);
          phase = PH_SYM1;
        end
      end
      PH_SYM1: begin
        v = {b, gath[7:0]};
        ofs = int'(v[15:3]) + 1;
        gath = '0;
        gath_cnt = 0;
        if (v[2:0] != 3'h7) begin
          begin_match(v[2:0] + 3);
        end else if (nib_held) begin
          nib_held = 1'b0;
          nibble_len(nib_val);
        end else begin
          phase = PH_NIBBLE;
        end
      end
      PH_NIBBLE: begin
        nib_held = 1'b1;
        nib_val = b[7:4];
        nibble_len(b[3:0]);
      end
      PH_LEN8: begin
        if (b != 8'hFF) begin
          begin_match(b + 25);
        end else begin
          phase = PH_LEN16;
          gath = '0;
          gath_cnt = 0;
        end
      end
      PH_LEN16, PH_LEN32: begin
        take_gather(b);
        if (gath_cnt >= ((phase == PH_LEN16) ? 2 : 4)) begin
          if (phase == PH_LEN16 && gath == 0) begin
            phase = PH_LEN32;
            gath_cnt = 0;
          end else if (gath < LenBias) begin
            sticky = ST_BAD_LEN;
          end else begin
            begin_match(longint'(gath) + 3);
          end
          if (gath_cnt >= 2) begin
            gath = '0;
            gath_cnt = 0;
          end
          if (phase == PH_LEN32) gath = '0;
        end
      end
      default: begin
        take_gather(b);
        if (gath_cnt >= 4) begin
          sym_next = gath[31];
          flags = {gath[30:0], 1'b1};
          gath = '0;
          gath_cnt = 0;
          phase = PH_ITEM;
        end
      end
    endcase
  endfunction

  function automatic void predict_item(comp_item_t it);
    status_e rep;
    logic [31:0] x;
    bit waiting;
    item_bytes.delete();
    if (sticky != ST_OK) begin
      rep = sticky;
    end else if (it.op == OP_DATA) begin
      if (copy_left != 0) rep = ST_MISUSE;
      else begin
        decode_byte(it.data);
        rep = sticky;
      end
    end else if (it.op == OP_DRAIN) begin
      if (copy_left == 0) rep = ST_MISUSE;
      else begin
        copy_burst();
        rep = sticky;
      end
    end else if (it.op == OP_END) begin
      if (copy_left != 0) rep = ST_MISUSE;
      else begin
        waiting = (phase == PH_ITEM) || (phase == PH_FLAGS && gath_cnt == 0);
        x = ~flags;
        sticky = (waiting && sym_next && (((x + 1) & x) == 0)) ? ST_DONE : ST_TRUNC;
        rep = sticky;
      end
    end else begin
      rep = ST_MISUSE;
    end
    if (item_bytes.size() == 0) item_bytes = {item_bytes, plain_byte_t'('0)};
    foreach (item_bytes[k]) begin
      item_bytes[k].last = (k == item_bytes.size() - 1);
      item_bytes[k].copy_pending = (copy_left != 0);
      item_bytes[k].status = rep;
      expected_bytes = {expected_bytes, item_bytes[k]};
    end
  endfunction

  function automatic void reset_mirror();
    wr_ptr = '0; win_fill = 0; flags = '0; sym_next = 1'b1; phase = PH_FLAGS;
    gath = '0; gath_cnt = 0; ofs = 0; nib_held = 1'b0; nib_val = '0;
    copy_left = 0; sticky = ST_OK;
  endfunction

  // stimulus builders; fill tracks written history so offsets stay legal
  int unsigned gen_fill;
  logic [31:0] gen_flags;
  int gen_bit;
  logic [7:0] gen_nib;
  bit gen_nib_open;

  task automatic push(op_e op, logic [7:0] d);
    comp_item_t it;
    it.op = op;
    it.data = d;
    pending_items = {pending_items, it};
  endtask

  task automatic open_block(logic [31:0] f);
    gen_flags = f;
    gen_bit = 31;
    for (int i = 0; i < 4; i++) push(OP_DATA, f[8*i +: 8]);
  endtask

  task automatic add_drains(longint unsigned len);
    longint unsigned left;
    left = (len > Burst) ? len - Burst : 0;
    while (left > 0) begin
      push(OP_DRAIN, 8'h00);
      left = (left > Burst) ? left - Burst : 0;
    end
  endtask

  // one element per flag bit; bit value comes from the flag word
  task automatic gen_element(int mode);
    logic [12:0] o;
    int len;
    if (gen_bit < 0) open_block($urandom());
    if (!gen_flags[gen_bit] || gen_fill == 0) begin
      if (gen_flags[gen_bit]) begin
        // a symbol with no history: the bad offset path is unavoidable here
      end
      if (!gen_flags[gen_bit]) begin
        push(OP_DATA, 8'($urandom()));
        gen_fill++;
        gen_bit--;
        return;
      end
    end
    o = 13'($urandom_range(0, (gen_fill > Window ? Window : gen_fill) - 1));
    if ($urandom_range(0, 7) == 0) o = 13'($urandom_range(0, 3));
    len = $urandom_range(0, 9);
    if (len < 7) begin
      push(OP_DATA, {o[4:0], 3'(len)});
      push(OP_DATA, o[12:5]);
      gen_fill += len + 3;
    end else begin
      int tot;
      push(OP_DATA, {o[4:0], 3'h7});
      push(OP_DATA, o[12:5]);
      tot = 0;
      if (!gen_nib_open) begin
        gen_nib = 8'($urandom());
        if ($urandom_range(0, 1)) gen_nib[3:0] = 4'($urandom_range(0, 14));
        push(OP_DATA, gen_nib);
        gen_nib_open = 1'b1;
        if (gen_nib[3:0] != 4'hF) tot = gen_nib[3:0] + 10;
      end else begin
        gen_nib_open = 1'b0;
        if (gen_nib[7:4] != 4'hF) tot = gen_nib[7:4] + 10;
      end
      if (tot == 0) begin
        int b;
        b = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 254);
        if (mode == 0 && b == 255) b = 254;
        push(OP_DATA, 8'(b));
        if (b < 255) tot = b + 25;
        else if ($urandom_range(0, 3) != 0) begin
          int v;
          v = $urandom_range(22, 400);
          push(OP_DATA, v[7:0]);
          push(OP_DATA, v[15:8]);
          tot = v + 3;
        end else begin
          int v;
          v = $urandom_range(22, 300);
          push(OP_DATA, 8'h00);
          push(OP_DATA, 8'h00);
          for (int i = 0; i < 4; i++) push(OP_DATA, v[8*i +: 8]);
          tot = v + 3;
        end
      end
      add_drains(tot);
      gen_fill += tot;
    end
    gen_bit--;
  endtask

  // build a stream of the given number of elements, then end it
  task automatic gen_stream(int elems);
    gen_fill = 0;
    gen_bit = -1;
    gen_nib_open = 1'b0;
    for (int i = 0; i < elems; i++) gen_element(1);
    push(OP_END, 8'h00);
  endtask

  // wait until mirror and DUT are idle, then keep the sender quiet for a while;
  // the block has no restart, so after an end every item just repeats the sticky status
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_bytes.size() != 0) @(posedge clk_i);
    hold_tx = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_tx = 1'b0;
  endtask

  // driver
  int tx_gap = 0;
  always @(posedge clk_i) begin
    comp_item_t it;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item(comp_item_t'({s_axis_tuser, s_axis_tdata}));
        void'(pending_items.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!hold_tx && pending_items.size() != 0) begin
        it = pending_items[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.op;
        s_axis_tdata <= it.data;
        if ($urandom_range(0, 3) == 0)
          tx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  int rx_gap = 0;
  always @(posedge clk_i) begin
    plain_byte_t got, exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_byte = m_axis_tdata;
        got.byte_valid = m_axis_tuser[0];
        got.copy_pending = m_axis_tuser[1];
        got.status = status_e'(m_axis_tuser[4:2]);
        got.last = m_axis_tlast;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output %p", got);
        end else begin
          exp_r = expected_bytes.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
      end
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 4) == 0)
          rx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    reset_mirror();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: misuse, literals, short and escaped matches, drains
    push(OP_DRAIN, 8'h00);
    push(OP_BAD, 8'hFF);
    open_block(32'h00FF_FFFF);       // 8 literals then symbols
    push(OP_DATA, 8'h00);
    push(OP_DATA, 8'hFF);
    for (int i = 0; i < 6; i++) push(OP_DATA, 8'(i * 37));
    push(OP_DATA, 8'h00); push(OP_DATA, 8'h00);              // ofs 1 len 3
    push(OP_DATA, 8'h0F); push(OP_DATA, 8'h00);              // ofs 2 nibble escape
    push(OP_DATA, 8'hF4);                                    // low 4, high 15
    push(OP_DATA, 8'h17); push(OP_DATA, 8'h00);              // ofs 3 uses held 15
    push(OP_DATA, 8'hFE);                                    // len 279
    push(OP_DATA, 8'h00);                                    // misuse while pending
    push(OP_END, 8'h00);                                     // misuse while pending
    add_drains(279);
    for (int i = 0; i < 26; i++) push(OP_DATA, 8'h00);        // ofs 1 len 3 each
    wait_drained();
    // the stream is still open here: the last eight flag bits of the block are left
    gen_fill = 8 + 3 + 14 + 279 + 39;
    gen_bit = 7;
    gen_nib_open = 1'b0;

    // fill with the receiver held so the block backs up
    hold_rx = 1'b1;
    for (int i = 0; i < 30; i++) gen_element(1);
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
    join_none
    for (int i = 0; i < 130; i++) gen_element(1);
    wait_drained();
    for (int i = 0; i < 80; i++) gen_element(0);
    // use up flag bits until only ones are left in the block
    while (gen_bit >= 0 &&
           ((~gen_flags) & ((32'd1 << (gen_bit + 1)) - 32'd1)) != '0) gen_element(1);
    push(OP_END, 8'h00);
    push(OP_DATA, 8'h55);            // sticky after end
    wait_drained();

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

endmodule
